/* hw/rtl/fss_pkg.sv */
// ----------------------------------------------------------------------------
// fss_pkg: shared types, constants and helpers of the fuzzy subsequence scorer
// Sizes, bonus weights, ASCII codes and the column broadcast word.
// ----------------------------------------------------------------------------
package fss_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int CHAR_BITS   = 16;
  localparam int SLOT_W      = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 6;
  localparam int SCORE_W     = 12;
  localparam int RUN_W       = 5;
  localparam int SEEN_W      = 6;
  localparam int GAIN_W      = 8;
  localparam int BONUS_W     = 4;

  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
  localparam logic [SEEN_W-1:0]  SEEN_MAX  = '1;

  // Bonus weights
  localparam logic [BONUS_W-1:0] BONUS_FIRST = 4'd8;
  localparam logic [BONUS_W-1:0] BONUS_BSL   = 4'd5;
  localparam logic [BONUS_W-1:0] BONUS_SEP   = 4'd4;
  localparam logic [BONUS_W-1:0] BONUS_DOT   = 4'd3;
  localparam logic [BONUS_W-1:0] BONUS_CAMEL = 4'd4;
  localparam logic [BONUS_W-1:0] BONUS_NONE  = 4'd0;

  // ASCII codes
  localparam logic [CHAR_BITS-1:0] CH_UP_A  = CHAR_BITS'(8'h41);
  localparam logic [CHAR_BITS-1:0] CH_UP_Z  = CHAR_BITS'(8'h5A);
  localparam logic [CHAR_BITS-1:0] CH_LO_A  = CHAR_BITS'(8'h61);
  localparam logic [CHAR_BITS-1:0] CH_LO_Z  = CHAR_BITS'(8'h7A);
  localparam logic [CHAR_BITS-1:0] CH_BSL   = CHAR_BITS'(8'h5C);
  localparam logic [CHAR_BITS-1:0] CH_SPACE = CHAR_BITS'(8'h20);
  localparam logic [CHAR_BITS-1:0] CH_UNDER = CHAR_BITS'(8'h5F);
  localparam logic [CHAR_BITS-1:0] CH_DOT   = CHAR_BITS'(8'h2E);
  localparam logic [CHAR_BITS-1:0] CASE_OFS = CHAR_BITS'(8'h20);

  // Word kind carried on in_tuser
  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TARGET  = 1'b1;

  // Broadcast from the control logic to every cell
  typedef struct packed {
    logic                 step;   // advance one column
    logic                 clear;  // drop the column after this step
    logic                 first;  // first target position
    logic [CHAR_BITS-1:0] chr;    // target or pattern character
    logic [BONUS_W-1:0]   bonus;  // position bonus shared by all rows
  } fss_bcast_t;

  function automatic logic is_upper(input logic [CHAR_BITS-1:0] c);
    return (c >= CH_UP_A) && (c <= CH_UP_Z);
  endfunction

  function automatic logic is_lower(input logic [CHAR_BITS-1:0] c);
    return (c >= CH_LO_A) && (c <= CH_LO_Z);
  endfunction

  function automatic logic [CHAR_BITS-1:0] fold(input logic [CHAR_BITS-1:0] c);
    return is_upper(c) ? c + CASE_OFS : c;
  endfunction

endpackage

/* hw/rtl/fss_cell.sv */
// ----------------------------------------------------------------------------
// fss_cell: one pattern row of the scoring column
// Holds the row's pattern character, best score and run length.
// ----------------------------------------------------------------------------
module fss_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  fss_pkg::fss_bcast_t             bcast,
  input  logic                            load_en,
  input  logic                            is_head,
  input  logic [fss_pkg::SCORE_W-1:0]     diag_score,
  input  logic [fss_pkg::RUN_W-1:0]       diag_run,
  output logic [fss_pkg::SCORE_W-1:0]     cur_score,
  output logic [fss_pkg::RUN_W-1:0]       cur_run,
  output logic [fss_pkg::SCORE_W-1:0]     step_score
);
  import fss_pkg::*;

  logic [CHAR_BITS-1:0] pat_r;
  logic [SCORE_W-1:0]   score_r, score_nxt;
  logic [RUN_W-1:0]     run_r, run_nxt;

  logic [SCORE_W-1:0]   left, diag;
  logic [RUN_W-1:0]     run;
  logic                 match, take;
  logic [GAIN_W-1:0]    gain;
  logic [SCORE_W:0]     sum;
  logic [SCORE_W-1:0]   new_score;
  logic [RUN_W-1:0]     new_run;

  always_comb begin
    left  = bcast.first ? '0 : score_r;
    diag  = bcast.first ? '0 : diag_score;
    run   = bcast.first ? '0 : diag_run;
    match = (fold(pat_r) == fold(bcast.chr)) && (is_head || (diag != '0));
    // 1 + 5*run + same case + position bonus
    gain  = GAIN_W'(1) + GAIN_W'({run, 2'b00}) + GAIN_W'(run)
          + GAIN_W'(pat_r == bcast.chr) + GAIN_W'(bcast.bonus);
    sum   = {1'b0, diag} + (SCORE_W+1)'(gain);
    take  = match && ({1'b0, left} <= sum);
    if (take) begin
      new_score = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
      new_run   = (run == RUN_MAX) ? RUN_MAX : run + RUN_W'(1);
    end else begin
      new_score = left;
      new_run   = '0;
    end
    score_nxt = score_r;
    run_nxt   = run_r;
    if (bcast.step) begin
      score_nxt = bcast.clear ? '0 : new_score;
      run_nxt   = bcast.clear ? '0 : new_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
      run_r   <= '0;
    end else begin
      score_r <= score_nxt;
      run_r   <= run_nxt;
    end
  end

  // Pattern character: no reset, written on load only
  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_r <= bcast.chr;
    end
  end

  assign cur_score  = score_r;
  assign cur_run    = run_r;
  assign step_score = new_score;

endmodule

/* hw/rtl/fuzzy_subsequence_scorer_unit.sv */
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer_unit: fuzzy match scorer, one cell per pattern row
// Loads pattern characters, then scores a streamed target one column a word.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake           | Carries
//  --------+-----------+---------------------+-------------------------------
//  in_     | slave     | in_tvalid/in_tready | pattern or target character
//  out_    | master    | out_tvalid/out_tready | final score of one target
//  cfg_    | write     | cfg_we              | pattern_length
//
//  Every accepted input word is processed in the cycle it is taken: all
//  MAX_PATTERN cells update one column together, each from its upper
//  neighbor's registered score and run. Sustained rate is one word a cycle
//  while in_tready is high. The result of a target word marked tlast sits in
//  the output register in the next cycle. in_tready drops only while that
//  register holds an untaken result. Reset (rst_n low, synchronous) clears
//  the column, previous character, count, pattern length (to 1) and the
//  output valid flag; pattern characters and output payload keep their value.
//
module fuzzy_subsequence_scorer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [15:0] char_code, [20:16] pattern_slot, [23:21] zero
  input  logic [23:0]                   in_tdata,
  // in_tuser: [0] mode (0 pattern load, 1 target character)
  input  logic                          in_tuser,
  input  logic                          in_tlast,    // end_of_target
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // out_tdata: [11:0] match_score, [15:12] zero
  output logic [15:0]                   out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [fss_pkg::LEN_W-1:0]     cfg_wdata    // pattern_length
);
  import fss_pkg::*;

  // Split the input word
  logic [CHAR_BITS-1:0] in_char;
  logic [SLOT_W-1:0]    in_slot;
  logic                 in_acc;
  logic                 tgt_step;

  assign in_char  = in_tdata[CHAR_BITS-1:0];
  assign in_slot  = in_tdata[CHAR_BITS +: SLOT_W];
  assign in_acc   = in_tvalid && in_tready;
  assign tgt_step = in_acc && (in_tuser == MODE_TARGET);

  // Control state
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [CHAR_BITS-1:0] prev_r, prev_nxt;
  logic [SEEN_W-1:0]    seen_r, seen_nxt, seen_inc;
  logic                 ovld_r, ovld_nxt;
  logic [SCORE_W-1:0]   odata_r, odata_nxt;

  logic                 first;
  logic [BONUS_W-1:0]   bonus;
  fss_bcast_t           bcast;

  assign first = (seen_r == '0);

  // Position bonus: first position, else from the previous target character (camel case also checks the current one)
  always_comb begin
    priority if (first) begin
      bonus = BONUS_FIRST;
    end else if (prev_r == CH_BSL) begin
      bonus = BONUS_BSL;
    end else if ((prev_r == CH_SPACE) || (prev_r == CH_UNDER)) begin
      bonus = BONUS_SEP;
    end else if (prev_r == CH_DOT) begin
      bonus = BONUS_DOT;
    end else if (is_lower(prev_r) && is_upper(in_char)) begin
      bonus = BONUS_CAMEL;
    end else begin
      bonus = BONUS_NONE;
    end
  end

  always_comb begin
    bcast.step  = tgt_step;
    bcast.clear = in_tlast;
    bcast.first = first;
    bcast.chr   = in_char;
    bcast.bonus = bonus;
  end

  // Row of cells, each fed by its upper neighbor
  logic [SCORE_W-1:0] cell_score [MAX_PATTERN];
  logic [RUN_W-1:0]   cell_run   [MAX_PATTERN];
  logic [SCORE_W-1:0] cell_step  [MAX_PATTERN];

  for (genvar p = 0; p < MAX_PATTERN; p++) begin : g_cell
    logic               load_en;
    logic [SCORE_W-1:0] diag_score;
    logic [RUN_W-1:0]   diag_run;

    assign load_en = in_acc && (in_tuser == MODE_PATTERN) && (in_slot == SLOT_W'(p));

    if (p == 0) begin : g_head
      assign diag_score = '0;
      assign diag_run   = '0;
    end else begin : g_body
      assign diag_score = cell_score[p-1];
      assign diag_run   = cell_run[p-1];
    end

    fss_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .bcast      (bcast),
      .load_en    (load_en),
      .is_head    (p == 0),
      .diag_score (diag_score),
      .diag_run   (diag_run),
      .cur_score  (cell_score[p]),
      .cur_run    (cell_run[p]),
      .step_score (cell_step[p])
    );
  end

  // Result selection: clamp length, pick the last active row
  logic [LEN_W-1:0]   len_eff;
  logic [SLOT_W-1:0]  row_sel;
  logic [SCORE_W-1:0] result;

  always_comb begin
    len_eff  = (len_r > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len_r;
    row_sel  = SLOT_W'(len_eff - LEN_W'(1));
    seen_inc = (seen_r == SEEN_MAX) ? seen_r : seen_r + SEEN_W'(1);
    if ((len_eff == '0) || (seen_inc < SEEN_W'(len_eff))) begin
      result = '0;
    end else begin
      result = cell_step[row_sel];
    end
  end

  always_comb begin
    len_nxt   = cfg_we ? cfg_wdata : len_r;
    prev_nxt  = prev_r;
    seen_nxt  = seen_r;
    ovld_nxt  = ovld_r && !out_tready;
    odata_nxt = odata_r;
    if (tgt_step) begin
      prev_nxt = in_tlast ? '0 : in_char;
      seen_nxt = in_tlast ? '0 : seen_inc;
      if (in_tlast) begin
        ovld_nxt  = 1'b1;
        odata_nxt = result;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_W'(1);
      prev_r <= '0;
      seen_r <= '0;
      ovld_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      prev_r <= prev_nxt;
      seen_r <= seen_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // Output payload: no reset, qualified by ovld_r
  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
  end

  // Accept while the output register is free or being drained
  assign in_tready  = !ovld_r || out_tready;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {4'b0000, odata_r};

endmodule

/* hw/rtl/fss_checker.sv */
// ----------------------------------------------------------------------------
// fss_checker: port-level checks of the fuzzy subsequence scorer
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module fss_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tuser,
  input logic                      in_tlast,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic [15:0]               out_tdata,
  input logic                      out_tvalid,
  input logic                      out_tready
);
  import fss_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // Input stalls only behind an untaken result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a pending result");

  // Last target word yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_TARGET) && in_tlast |=> out_tvalid)
    else $error("no result after last target word");

  // Pattern load never creates a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_PATTERN) && !out_tvalid |=> !out_tvalid)
    else $error("result appeared after a pattern load");

  // Padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] == 4'b0000))
    else $error("nonzero padding in result word");

endmodule

bind fuzzy_subsequence_scorer_unit fss_checker u_fss_checker (.*);
